[sv/assert_macros.svh]
// assertion macros shared by the button classifier rtl
// depends on nothing; each file that asserts includes this header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define BCLH_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define BCLH_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/bclh_pkg.sv]
// types, constants and register codes for the button click/long/hold classifier
// no dependencies
package bclh_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int DEB_W  = 8;
  localparam int THR_W  = 16;
  localparam int HELD_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd25;
  localparam logic [THR_W-1:0] LONG_RESET     = 16'd800;
  localparam logic [THR_W-1:0] HOLD_RESET     = 16'd3000;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2,
    EV_HOLD  = 2'd3
  } bclh_event_t;

  typedef struct packed {
    logic stable_level;
    logic press_active;
    logic long_done;
    logic hold_done;
  } bclh_flags_t;

  typedef struct packed {
    bclh_event_t             event_res;
    logic                    activity;
    logic [HELD_W-1:0]       held_ticks;
  } bclh_result_t;

endpackage

[sv/bclh_in_if.sv]
// request channel carrying one tick: pin level and request flags
// no dependencies
interface bclh_in_if;
  logic valid;
  logic ready;
  logic level;
  logic force_click;
  logic rearm;

  modport source (output valid, level, force_click, rearm, input ready);
  modport sink   (input valid, level, force_click, rearm, output ready);
endinterface

[sv/bclh_out_if.sv]
// result channel: event code, activity flag and held time
// depends on bclh_pkg
interface bclh_out_if
  import bclh_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        event_res;
  logic              activity;
  logic [HELD_W-1:0] held_ticks;

  modport source (output valid, event_res, activity, held_ticks, input ready);
  modport sink   (input valid, event_res, activity, held_ticks, output ready);
endinterface

[sv/bclh_cfg_if.sv]
// configuration write channel: register index and write data
// depends on bclh_pkg
interface bclh_cfg_if
  import bclh_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/bclh_step.sv]
// next-state and result logic for one tick of the classifier
// depends on bclh_pkg
module bclh_step
  import bclh_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic [DEB_W-1:0]       debounce_ms,
  input  logic [THR_W-1:0]       long_ms,
  input  logic [THR_W-1:0]       hold_ms,
  input  bclh_flags_t            flags,
  input  logic [COUNT_WIDTH-1:0] since_edge,
  input  logic [COUNT_WIDTH-1:0] held_count,
  input  logic                   level,
  input  logic                   force_click,
  input  logic                   rearm,
  output bclh_flags_t            flags_next,
  output logic [COUNT_WIDTH-1:0] since_edge_next,
  output logic [COUNT_WIDTH-1:0] held_count_next,
  output bclh_result_t           result
);

  // compare width wide enough for both counters and thresholds
  localparam int CW = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [CW-1:0] HELD_MAX = CW'({HELD_W{1'b1}});

  bclh_flags_t            f;
  logic [COUNT_WIDTH-1:0] se;
  logic [COUNT_WIDTH-1:0] hc;
  logic [CW-1:0]          hc_ext;
  bclh_event_t            ev;
  logic                   act;
  logic [HELD_W-1:0]      held;

  always_comb begin
    f  = flags;
    se = (since_edge == CNT_MAX) ? since_edge : since_edge + COUNT_WIDTH'(1);
    hc = held_count;
    if (flags.press_active && held_count != CNT_MAX) begin
      hc = held_count + COUNT_WIDTH'(1);
    end

    if (rearm) begin
      f.stable_level = level;
      f.press_active = 1'b0;
      f.long_done    = 1'b1;
      f.hold_done    = 1'b1;
      se = '0;
      hc = '0;
    end

    ev  = EV_NONE;
    act = 1'b0;
    hc_ext = CW'(hc);

    priority if (force_click) begin
      ev = EV_CLICK;
    end else if (level != f.stable_level) begin
      act = 1'b1;
      // edge outside the debounce window is taken
      if (CW'(se) >= CW'(debounce_ms)) begin
        se = '0;
        f.stable_level = level;
        if (!level) begin
          f.press_active = 1'b1;
          f.long_done    = 1'b0;
          f.hold_done    = 1'b0;
        end else begin
          if (f.press_active && !f.long_done) begin
            ev = EV_CLICK;
          end
          f.press_active = 1'b0;
        end
        hc = '0;
      end
    end else if (!level && f.press_active) begin
      // at most one event per tick, long before hold
      if (!f.long_done && hc_ext > CW'(long_ms)) begin
        f.long_done = 1'b1;
        ev = EV_LONG;
      end else if (f.long_done && !f.hold_done && hc_ext > CW'(hold_ms)) begin
        f.hold_done = 1'b1;
        ev = EV_HOLD;
      end
    end else begin
      // steady level with no press to time
      ev = EV_NONE;
    end

    hc_ext = CW'(hc);
    priority if (!f.press_active) begin
      held = '0;
    end else if (hc == '0) begin
      held = HELD_W'(1);
    end else if (hc_ext > HELD_MAX) begin
      held = {HELD_W{1'b1}};
    end else begin
      held = hc_ext[HELD_W-1:0];
    end
  end

  assign flags_next        = f;
  assign since_edge_next   = se;
  assign held_count_next   = hc;
  assign result.event_res  = ev;
  assign result.activity   = act;
  assign result.held_ticks = held;

endmodule

[sv/button_click_long_hold_classifier.sv]
// top level of the button click/long/hold classifier
// depends on bclh_pkg, bclh_in_if, bclh_out_if, bclh_cfg_if, bclh_step, assert_macros.svh
//
// din carries one millisecond tick per request: the active-low pin level and
// the forced-click and re-arm flags. dout returns exactly one result per tick:
// event code, raw-activity flag and held time. cfg writes debounce_ms (index 0),
// long_ms (index 1) and hold_ms (index 2); other indexes are ignored and the
// port is always ready.
// The tick is evaluated in the cycle it is accepted; state and result are
// registered together, so a result appears in the cycle after its request is accepted.
// One tick per cycle is sustained while dout.ready stays high: the output register is
// refilled in the same cycle it is taken. When the receiver stalls, the result register
// holds and din.ready drops until the result is taken, so the state never runs ahead.
// Synchronous reset loads the register defaults (25, 800, 3000), sets the
// stable level to released, saturates the edge counter and clears the press.
`include "assert_macros.svh"

module button_click_long_hold_classifier
  import bclh_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bclh_in_if.sink    din,
  bclh_out_if.source dout,
  bclh_cfg_if.sink   cfg
);

  logic [DEB_W-1:0]       debounce_ms;
  logic [THR_W-1:0]       long_ms;
  logic [THR_W-1:0]       hold_ms;

  bclh_flags_t            flags;
  logic [COUNT_WIDTH-1:0] since_edge;
  logic [COUNT_WIDTH-1:0] held_count;

  bclh_flags_t            flags_next;
  logic [COUNT_WIDTH-1:0] since_edge_next;
  logic [COUNT_WIDTH-1:0] held_count_next;
  bclh_result_t           result;

  bclh_result_t           res_q;
  logic                   out_valid;
  logic                   take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      long_ms     <= LONG_RESET;
      hold_ms     <= HOLD_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEBOUNCE: debounce_ms <= cfg.data[DEB_W-1:0];
        REG_LONG:     long_ms     <= cfg.data[THR_W-1:0];
        REG_HOLD:     hold_ms     <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  bclh_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .debounce_ms     (debounce_ms),
    .long_ms         (long_ms),
    .hold_ms         (hold_ms),
    .flags           (flags),
    .since_edge      (since_edge),
    .held_count      (held_count),
    .level           (din.level),
    .force_click     (din.force_click),
    .rearm           (din.rearm),
    .flags_next      (flags_next),
    .since_edge_next (since_edge_next),
    .held_count_next (held_count_next),
    .result          (result)
  );

  // accept whenever the result register is empty or being drained
  assign din.ready = !out_valid || dout.ready;
  assign take      = din.valid && din.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '{stable_level: 1'b1, press_active: 1'b0,
                      long_done: 1'b0, hold_done: 1'b0};
      since_edge <= {COUNT_WIDTH{1'b1}};
      held_count <= '0;
      out_valid  <= 1'b0;
    end else if (take) begin
      flags      <= flags_next;
      since_edge <= since_edge_next;
      held_count <= held_count_next;
      out_valid  <= 1'b1;
    end else if (dout.ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= result;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.event_res  = res_q.event_res;
  assign dout.activity   = res_q.activity;
  assign dout.held_ticks = res_q.held_ticks;

  `BCLH_ASSERT(a_held_matches_press, clk, rst, out_valid |-> ((res_q.held_ticks != '0) == flags.press_active), "held time disagrees with press state")
  `BCLH_ASSERT(a_long_marks_done, clk, rst, (out_valid && res_q.event_res == EV_LONG) |-> flags.long_done, "long event without long_done")
  `BCLH_ASSERT(a_hold_after_long, clk, rst, (out_valid && res_q.event_res == EV_HOLD) |-> (flags.long_done && flags.hold_done), "hold event out of order")
  `BCLH_ASSERT(a_stall_holds_state, clk, rst, (out_valid && !dout.ready) |=> ($stable(flags) && $stable(held_count)), "state moved while result stalled")

endmodule
